// ===== rtl/wsc_pkg.sv =====
// Shared types, constants and codes of the window sender congestion control block.
`timescale 1ns / 1ps

package wsc_pkg;

  localparam int SEQ_W  = 20;
  localparam int CNT_W  = 16;
  localparam int WIN_W  = 7;
  localparam int X_W    = 24;
  localparam int PROD_W = 2 * X_W;
  localparam int Q_LSB  = 27;
  localparam int STEP_W = $clog2(CNT_W + 1);

  localparam logic [SEQ_W-1:0] SEQ_MAX       = {SEQ_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [WIN_W-1:0] MAX_WINDOW    = 7'd64;
  localparam logic [WIN_W-1:0] NO_ACK_WINDOW = 7'd20;
  localparam logic [WIN_W-1:0] THRESH_MIN    = 7'd10;
  localparam logic [WIN_W-1:0] RETX_DUP      = 7'd5;
  localparam logic [SEQ_W-1:0] HS_RTT_MIN    = 20'd7000;
  localparam logic [SEQ_W-1:0] RTT_MIN       = 20'd2000;
  localparam logic [X_W-1:0]   RTT_MIN_X10   = 24'd20000;
  // Rounded-up reciprocal of ten, scaled by two to the power Q_LSB.
  localparam logic [X_W-1:0]   RECIP10       = 24'd13421773;

  localparam logic [SEQ_W-1:0] RESET_FINAL_SEG = 20'd1;
  localparam logic [WIN_W-1:0] RESET_WINDOW    = 7'd50;
  localparam logic [WIN_W-1:0] RESET_THRESH    = 7'd20;
  localparam logic [SEQ_W-1:0] RESET_RTT       = 20'd300;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_FINAL_SEG   = 2'd0;
  localparam logic [1:0] REG_INIT_WINDOW = 2'd1;
  localparam logic [1:0] REG_INIT_THRESH = 2'd2;

  typedef enum logic [1:0] {
    ACT_HANDSHAKE = 2'd0,
    ACT_START     = 2'd1,
    ACT_ACK       = 2'd2,
    ACT_QUIET     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BURST,
    ST_DIV,
    ST_APPLY,
    ST_ENDCHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] final_seg;
    logic [WIN_W-1:0] init_window;
    logic [WIN_W-1:0] init_thresh;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic rem_start;
    logic burst_emit;
    logic apply;
    logic endchk;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    burst_stop;
    logic    burst_last;
    logic    out_free;
    logic    rem_busy;
  } sts_t;

endpackage

// ===== rtl/window_sender_congestion_control.sv =====
// Top level of the window sender congestion control block: registers, controller, datapath.
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_stall    action, ack_number, elapsed_us
//   result    out        result_valid / result_stall kind .. quiet_wait_us
//   config    in         psel, penable, pwrite      paddr, pwdata, prdata
//
// A handshake executes and emits a status beat; a quiet expiry checks the round end first.
// A start round sends one segment beat per cycle unless stalled, up to the window.
// An ack waits on the 16-step remainder of the duplicate count before its status beat.
// Reset is synchronous, with no clearing pass.
// A stalled result holds the block at its next beat; a new item is taken while a result waits.
`timescale 1ns / 1ps

module window_sender_congestion_control (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 action,
  input  logic [wsc_pkg::SEQ_W-1:0]  ack_number,
  input  logic [wsc_pkg::SEQ_W-1:0]  elapsed_us,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       kind,
  output logic [wsc_pkg::SEQ_W-1:0]  segment_number,
  output logic                       last_of_run,
  output logic                       round_over,
  output logic                       transfer_done,
  output logic [wsc_pkg::WIN_W-1:0]  window_now,
  output logic [wsc_pkg::SEQ_W-1:0]  rtt_now,
  output logic [wsc_pkg::SEQ_W-2:0]  quiet_wait_us,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wsc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.final_seg   <= RESET_FINAL_SEG;
      cfg.init_window <= RESET_WINDOW;
      cfg.init_thresh <= RESET_THRESH;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_FINAL_SEG:   cfg.final_seg   <= pwdata[SEQ_W-1:0];
        REG_INIT_WINDOW: cfg.init_window <= pwdata[WIN_W-1:0];
        REG_INIT_THRESH: cfg.init_thresh <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FINAL_SEG:   prdata = {{(32-SEQ_W){1'b0}}, cfg.final_seg};
      REG_INIT_WINDOW: prdata = {{(32-WIN_W){1'b0}}, cfg.init_window};
      REG_INIT_THRESH: prdata = {{(32-WIN_W){1'b0}}, cfg.init_thresh};
      default:         prdata = '0;
    endcase
  end

  wsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  wsc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .action         (action),
    .ack_number     (ack_number),
    .elapsed_us     (elapsed_us),
    .result_stall   (result_stall),
    .sts            (sts),
    .result_valid   (result_valid),
    .kind           (kind),
    .segment_number (segment_number),
    .last_of_run    (last_of_run),
    .round_over     (round_over),
    .transfer_done  (transfer_done),
    .window_now     (window_now),
    .rtt_now        (rtt_now),
    .quiet_wait_us  (quiet_wait_us)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("block took a second item while the first was in progress");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind) |-> last_of_run)
    else $error("status beat not marked as last of its run");

  a_segment_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !kind) |-> (segment_number != '0))
    else $error("segment beat carries segment number zero");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((window_now != '0) && (window_now <= MAX_WINDOW)))
    else $error("window out of range on a result beat");
`endif

endmodule

// ===== rtl/wsc_rem.sv =====
// Iterative remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module wsc_rem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [wsc_pkg::CNT_W-1:0] dividend,
  input  logic [wsc_pkg::WIN_W-1:0] divisor,
  output logic                      busy,
  output logic [wsc_pkg::WIN_W-1:0] rem
);
  import wsc_pkg::*;

  logic [CNT_W-1:0]  quo;
  logic [STEP_W-1:0] steps;
  logic [WIN_W:0]    trial;

  assign trial = {rem, quo[CNT_W-1]};
  assign busy  = (steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(CNT_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= WIN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[WIN_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/wsc_dp.sv =====
// Datapath: sender state, round trip arithmetic, window update and result register.
`timescale 1ns / 1ps

module wsc_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  wsc_pkg::cmd_t             cmd,
  input  wsc_pkg::cfg_t             cfg,
  input  logic [1:0]                action,
  input  logic [wsc_pkg::SEQ_W-1:0] ack_number,
  input  logic [wsc_pkg::SEQ_W-1:0] elapsed_us,
  input  logic                      result_stall,
  output wsc_pkg::sts_t             sts,
  output logic                      result_valid,
  output logic                      kind,
  output logic [wsc_pkg::SEQ_W-1:0] segment_number,
  output logic                      last_of_run,
  output logic                      round_over,
  output logic                      transfer_done,
  output logic [wsc_pkg::WIN_W-1:0] window_now,
  output logic [wsc_pkg::SEQ_W-1:0] rtt_now,
  output logic [wsc_pkg::SEQ_W-2:0] quiet_wait_us
);
  import wsc_pkg::*;

  function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W:0] w);
    if (w == '0) begin
      return WIN_W'(1);
    end else if (w > {1'b0, MAX_WINDOW}) begin
      return MAX_WINDOW;
    end else begin
      return w[WIN_W-1:0];
    end
  endfunction

  function automatic logic [SEQ_W-1:0] sat_seq_inc(input logic [SEQ_W-1:0] v);
    return (v == SEQ_MAX) ? SEQ_MAX : v + SEQ_W'(1);
  endfunction

  action_t          act_q;
  logic [SEQ_W-1:0] ack_q;
  logic [SEQ_W-1:0] el_q;

  logic [SEQ_W-1:0] next_seg;
  logic [SEQ_W-1:0] exp_ack;
  logic [CNT_W-1:0] dup_cnt;
  logic [WIN_W-1:0] win;
  logic [WIN_W-1:0] thresh;
  logic             loss;
  logic [CNT_W-1:0] acks;
  logic [SEQ_W-1:0] rnd_first;
  logic [SEQ_W-1:0] rnd_end;
  logic [SEQ_W-1:0] rtt;
  logic [SEQ_W-1:0] rtt_hs;
  logic [SEQ_W-1:0] fin_sent;
  logic             fin_valid;

  logic [WIN_W-1:0]  slot;
  logic              done_pred;
  logic              retx;
  logic [SEQ_W-1:0]  retx_seg;
  logic              rtt_upd;
  logic              over;
  logic [X_W-1:0]    x_sum;
  logic [PROD_W-1:0] prod;

  logic             rem_busy;
  logic [WIN_W-1:0] rem;

  logic [SEQ_W:0]   a1;
  logic [CNT_W-1:0] dup_next;
  logic [SEQ_W-1:0] ea_next;
  logic [SEQ_W:0]   re_m1;
  logic [X_W-1:0]   el_x;
  logic [X_W-1:0]   el15;
  logic [X_W-1:0]   sum9;
  logic             rtt_cond;
  logic             retx_cond;
  logic [WIN_W-1:0] half;
  logic [WIN_W-1:0] th_loss;
  logic [WIN_W:0]   w_raw;
  logic             round_end;
  logic             done_live;
  logic             burst_hits;
  logic             done_burst;
  logic [SEQ_W-1:0] rtt_new;
  logic             out_free;

  wsc_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rem_start),
    .dividend (dup_next),
    .divisor  (win),
    .busy     (rem_busy),
    .rem      (rem)
  );

  always_comb begin
    a1       = {1'b0, ack_q} + (SEQ_W+1)'(1);
    dup_next = ({1'b0, exp_ack} == a1)
             ? ((dup_cnt == CNT_MAX) ? dup_cnt : dup_cnt + CNT_W'(1)) : '0;
    if (a1 >= {1'b0, exp_ack}) begin
      ea_next = (a1 > {1'b0, SEQ_MAX}) ? SEQ_MAX : a1[SEQ_W-1:0];
    end else begin
      ea_next = exp_ack;
    end
    re_m1    = {1'b0, rnd_end} - (SEQ_W+1)'(1);
    el_x     = {{(X_W-SEQ_W){1'b0}}, el_q};
    el15     = (el_x << 4) - el_x;
    sum9     = {{(X_W-SEQ_W){1'b0}}, rtt} + (el_x << 3) + el_x;
    // elapsed above rtt_hs / 15 is the same as rtt_hs below 15 * elapsed.
    rtt_cond = ((rnd_end == ea_next) || (re_m1 == {1'b0, ea_next})) && (el_q != '0)
             && ({{(X_W-SEQ_W){1'b0}}, rtt_hs} < el15);
    retx_cond = (rem == RETX_DUP)
              && !(fin_valid && ((next_seg - SEQ_W'(1)) == fin_sent));
    half     = {1'b0, win[WIN_W-1:1]};
    th_loss  = (half < THRESH_MIN) ? THRESH_MIN : half;
    priority if (acks == '0) begin
      w_raw = {1'b0, NO_ACK_WINDOW};
    end else if (!loss) begin
      w_raw = (win < thresh) ? {win, 1'b0} : {1'b0, win} + (WIN_W+1)'(1);
    end else begin
      w_raw = {1'b0, thresh};
    end
    round_end  = ((act_q == ACT_ACK) || (act_q == ACT_QUIET)) && (el_q >= rtt);
    done_live  = fin_valid && ((exp_ack - SEQ_W'(1)) == fin_sent);
    burst_hits = (next_seg <= cfg.final_seg)
               && ((cfg.final_seg - next_seg) < {{(SEQ_W-WIN_W){1'b0}}, win});
    done_burst = burst_hits ? ((exp_ack - SEQ_W'(1)) == cfg.final_seg) : done_live;
    rtt_new    = (x_sum < RTT_MIN_X10) ? RTT_MIN : prod[Q_LSB+SEQ_W-1:Q_LSB];
    out_free   = !result_valid || !result_stall;
  end

  assign sts.action     = act_q;
  assign sts.burst_stop = (next_seg > cfg.final_seg);
  assign sts.burst_last = (next_seg == cfg.final_seg) || (slot == win - WIN_W'(1));
  assign sts.out_free   = out_free;
  assign sts.rem_busy   = rem_busy;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q <= action_t'(action);
      ack_q <= ack_number;
      el_q  <= elapsed_us;
    end
    if (cmd.exec) begin
      x_sum <= sum9;
    end
    prod <= x_sum * RECIP10;
    if (cmd.apply) begin
      retx_seg <= next_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seg  <= SEQ_W'(1);
      exp_ack   <= SEQ_W'(1);
      dup_cnt   <= '0;
      win       <= RESET_WINDOW;
      thresh    <= RESET_THRESH;
      loss      <= 1'b0;
      acks      <= '0;
      rnd_first <= SEQ_W'(1);
      rnd_end   <= SEQ_W'(1);
      rtt       <= RESET_RTT;
      rtt_hs    <= '0;
      fin_sent  <= '0;
      fin_valid <= 1'b0;
      slot      <= '0;
      done_pred <= 1'b0;
      retx      <= 1'b0;
      rtt_upd   <= 1'b0;
      over      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        retx <= 1'b0;
        over <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (act_q)
          ACT_HANDSHAKE: begin
            rtt       <= (el_q < HS_RTT_MIN) ? HS_RTT_MIN : el_q;
            rtt_hs    <= (el_q < HS_RTT_MIN) ? HS_RTT_MIN : el_q;
            next_seg  <= SEQ_W'(2);
            exp_ack   <= SEQ_W'(1);
            dup_cnt   <= '0;
            win       <= clamp_win({1'b0, cfg.init_window});
            thresh    <= cfg.init_thresh;
            loss      <= 1'b0;
            acks      <= '0;
            rnd_first <= SEQ_W'(2);
            rnd_end   <= SEQ_W'(2);
            fin_valid <= (cfg.final_seg == SEQ_W'(1));
            fin_sent  <= (cfg.final_seg == SEQ_W'(1)) ? SEQ_W'(1) : '0;
          end
          ACT_START: begin
            rnd_first <= next_seg;
            rnd_end   <= next_seg;
            slot      <= '0;
            done_pred <= done_burst;
          end
          ACT_ACK: begin
            dup_cnt  <= dup_next;
            exp_ack  <= ea_next;
            next_seg <= ea_next;
            acks     <= (acks == CNT_MAX) ? acks : acks + CNT_W'(1);
            rtt_upd  <= rtt_cond;
          end
          ACT_QUIET: begin
            next_seg <= rnd_first;
          end
          default: ;
        endcase
      end
      if (cmd.burst_emit) begin
        slot <= slot + WIN_W'(1);
        if (next_seg == cfg.final_seg) begin
          fin_sent  <= next_seg;
          fin_valid <= 1'b1;
        end else begin
          next_seg <= sat_seq_inc(next_seg);
          rnd_end  <= sat_seq_inc(next_seg);
        end
      end
      if (cmd.apply) begin
        if (retx_cond) begin
          retx     <= 1'b1;
          next_seg <= sat_seq_inc(next_seg);
          loss     <= 1'b1;
          thresh   <= th_loss;
        end
        if (rtt_upd) begin
          rtt <= rtt_new;
        end
      end
      if (cmd.endchk && round_end) begin
        win  <= clamp_win(w_raw);
        acks <= '0;
        loss <= 1'b0;
        over <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.burst_emit || cmd.emit_final) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.burst_emit) begin
      kind           <= 1'b0;
      segment_number <= next_seg;
      last_of_run    <= sts.burst_last;
      round_over     <= 1'b0;
      transfer_done  <= done_pred;
      window_now     <= win;
      rtt_now        <= rtt;
      quiet_wait_us  <= rtt[SEQ_W-1:1];
    end else if (cmd.emit_final) begin
      kind           <= !retx;
      segment_number <= retx ? retx_seg : '0;
      last_of_run    <= 1'b1;
      round_over     <= over;
      transfer_done  <= done_live;
      window_now     <= win;
      rtt_now        <= rtt;
      quiet_wait_us  <= rtt[SEQ_W-1:1];
    end
  end

endmodule

// ===== rtl/wsc_ctrl.sv =====
// Controller: sequences each input beat through the datapath.
`timescale 1ns / 1ps

module wsc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  wsc_pkg::sts_t sts,
  output wsc_pkg::cmd_t cmd
);
  import wsc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.action)
          ACT_HANDSHAKE: state_next = ST_EMIT;
          ACT_START:     state_next = ST_BURST;
          ACT_ACK: begin
            cmd.rem_start = 1'b1;
            state_next    = ST_DIV;
          end
          ACT_QUIET:     state_next = ST_ENDCHK;
          default:       state_next = ST_IDLE;
        endcase
      end
      ST_BURST: begin
        // Nothing to send at the first slot yields one status beat instead.
        if (sts.burst_stop) begin
          state_next = ST_EMIT;
        end else if (sts.out_free) begin
          cmd.burst_emit = 1'b1;
          if (sts.burst_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (!sts.rem_busy) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_ENDCHK;
      end
      ST_ENDCHK: begin
        cmd.endchk = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sim/window_sender_congestion_control_tb.sv =====
// Self-checking testbench for the window sender congestion control block.
`timescale 1ns / 1ps

module window_sender_congestion_control_tb;
  import wsc_pkg::*;

  localparam int unsigned SEQ_LIMIT     = 32'h000F_FFFF;
  localparam int unsigned COUNT_LIMIT   = 32'h0000_FFFF;
  localparam int unsigned WINDOW_CAP    = 64;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  seg;
    logic              last;
    logic              over;
    logic              done;
    logic [WIN_W-1:0]  window;
    logic [SEQ_W-1:0]  rtt;
    logic [SEQ_W-2:0]  quiet;
  } sender_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         action = ACT_HANDSHAKE;
  logic [SEQ_W-1:0]   ack_number = '0;
  logic [SEQ_W-1:0]   elapsed_us = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               kind;
  logic [SEQ_W-1:0]   segment_number;
  logic               last_of_run;
  logic               round_over;
  logic               transfer_done;
  logic [WIN_W-1:0]   window_now;
  logic [SEQ_W-1:0]   rtt_now;
  logic [SEQ_W-2:0]   quiet_wait_us;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  window_sender_congestion_control dut (.*);

  // Shadow of the sender state and its configuration registers.
  int unsigned cfg_final = 1;
  int unsigned cfg_win = 50;
  int unsigned cfg_thresh = 20;
  int unsigned nxt_seg = 1;
  int unsigned ack_expect = 1;
  int unsigned dup_cnt = 0;
  int unsigned win = 50;
  int unsigned ssthresh = 20;
  bit          loss_flag = 1'b0;
  int unsigned round_acks = 0;
  int unsigned round_start_seg = 1;
  int unsigned round_stop_seg = 1;
  int unsigned rtt_est = 300;
  int unsigned rtt_hs = 0;
  int unsigned last_seg_sent = 0;
  bit          last_seg_valid = 1'b0;

  sender_beat_t predicted_beats[$];
  sender_beat_t want;
  int unsigned  error_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  beats_checked = 0;
  int unsigned  resend_count = 0;
  int unsigned  round_end_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_left = 0;
  int unsigned  draw = 0;
  bit           idle_free = 1'b0;

  always #2 clk = ~clk;

  function automatic int unsigned clamp_window(input int unsigned w);
    return (w == 0) ? 1 : ((w > WINDOW_CAP) ? WINDOW_CAP : w);
  endfunction

  function automatic int unsigned step_seq(input int unsigned s);
    return (s >= SEQ_LIMIT) ? SEQ_LIMIT : s + 1;
  endfunction

  function automatic int unsigned calm_elapsed();
    return $urandom_range(0, rtt_est / 2);
  endfunction

  task automatic predict_sender_beats(input action_t act, input int unsigned ack_in,
                                      input int unsigned el_in);
    int unsigned  segs[$];
    int unsigned  ack;
    int unsigned  el;
    int unsigned  a1;
    int unsigned  half;
    int unsigned  grown;
    int unsigned  slot;
    int unsigned  seg_val;
    bit           over;
    bit           done;
    bit           report_only;
    sender_beat_t beat;
    ack = ack_in & SEQ_LIMIT;
    el = el_in & SEQ_LIMIT;
    over = 1'b0;
    case (act)
      ACT_HANDSHAKE: begin
        rtt_est = (el < 7000) ? 7000 : el;
        rtt_hs = rtt_est;
        nxt_seg = 2;
        ack_expect = 1;
        dup_cnt = 0;
        win = clamp_window(cfg_win);
        ssthresh = cfg_thresh;
        loss_flag = 1'b0;
        round_acks = 0;
        round_start_seg = 2;
        round_stop_seg = 2;
        last_seg_valid = (cfg_final == 1);
        last_seg_sent = last_seg_valid ? 1 : 0;
      end
      ACT_START: begin
        round_start_seg = nxt_seg;
        for (slot = 0; slot < win; slot++) begin
          if (nxt_seg == cfg_final) begin
            segs.push_back(nxt_seg);
            last_seg_sent = nxt_seg;
            last_seg_valid = 1'b1;
            break;
          end else if (nxt_seg < cfg_final) begin
            segs.push_back(nxt_seg);
            nxt_seg = step_seq(nxt_seg);
          end
        end
        round_stop_seg = nxt_seg;
      end
      ACT_ACK: begin
        a1 = ack + 1;
        if (ack_expect == a1) begin
          if (dup_cnt < COUNT_LIMIT) dup_cnt++;
        end else begin
          dup_cnt = 0;
        end
        if (a1 >= ack_expect) ack_expect = (a1 > SEQ_LIMIT) ? SEQ_LIMIT : a1;
        nxt_seg = ack_expect;
        if (dup_cnt % win == 5 && !(last_seg_valid && nxt_seg - 32'd1 == last_seg_sent)) begin
          half = win / 2;
          segs.push_back(nxt_seg);
          nxt_seg = step_seq(nxt_seg);
          loss_flag = 1'b1;
          ssthresh = (half < 10) ? 10 : half;
          resend_count++;
        end
        if (round_acks < COUNT_LIMIT) round_acks++;
        if (round_stop_seg == ack_expect || round_stop_seg - 32'd1 == ack_expect) begin
          if (el > 0 && el > rtt_hs / 15) begin
            grown = (rtt_est + 9 * el) / 10;
            rtt_est = (grown < 2000) ? 2000 : grown;
          end
        end
      end
      default: begin
        nxt_seg = round_start_seg;
      end
    endcase

    if ((act == ACT_ACK || act == ACT_QUIET) && el >= rtt_est) begin
      if (round_acks == 0) grown = 20;
      else if (!loss_flag) grown = (win < ssthresh) ? win * 2 : win + 1;
      else grown = ssthresh;
      win = clamp_window(grown);
      round_acks = 0;
      loss_flag = 1'b0;
      over = 1'b1;
      round_end_count++;
    end

    done = last_seg_valid && (ack_expect - 32'd1 == last_seg_sent);
    report_only = (segs.size() == 0);
    if (report_only) segs.push_back(0);
    half = rtt_est / 2;
    for (slot = 0; slot < segs.size(); slot++) begin
      seg_val = segs[slot];
      beat.kind = report_only;
      beat.seg = seg_val[SEQ_W-1:0];
      beat.last = (slot == segs.size() - 1);
      beat.over = over;
      beat.done = done;
      beat.window = win[WIN_W-1:0];
      beat.rtt = rtt_est[SEQ_W-1:0];
      beat.quiet = half[SEQ_W-2:0];
      predicted_beats.push_back(beat);
    end
  endtask

  task automatic send_item(input action_t act, input int unsigned ack, input int unsigned el);
    int unsigned gap;
    gap = idle_free ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    ack_number <= ack[SEQ_W-1:0];
    elapsed_us <= el[SEQ_W-1:0];
    do @(posedge clk); while (item_stall);
    items_sent++;
    predict_sender_beats(act, ack, el);
  endtask

  task automatic drain_results(input int unsigned settle);
    item_valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FINAL_SEG: cfg_final = value & SEQ_LIMIT;
      REG_INIT_WINDOW: cfg_win = value & 32'h7F;
      REG_INIT_THRESH: cfg_thresh = value & 32'h7F;
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned final_seg, input int unsigned init_win,
                            input int unsigned init_thresh);
    write_reg(REG_FINAL_SEG, final_seg);
    write_reg(REG_INIT_WINDOW, init_win);
    write_reg(REG_INIT_THRESH, init_thresh);
  endtask

  task automatic test_power_on_state();
    send_item(ACT_START, 0, 0);
    send_item(ACT_ACK, SEQ_LIMIT, SEQ_LIMIT);
    send_item(ACT_HANDSHAKE, 0, 8000);
    send_item(ACT_QUIET, 0, 0);
    drain_results(SETTLE_CYCLES);
  endtask

  task automatic test_window_rounds();
    set_config(40, 8, 10);
    send_item(ACT_HANDSHAKE, 0, 0);
    send_item(ACT_START, 0, 0);
    repeat (6) send_item(ACT_ACK, 1, 0);
    send_item(ACT_ACK, 9, 100);
    send_item(ACT_ACK, 9, 7000);
    drain_results(1);
    send_item(ACT_START, 0, 0);
    send_item(ACT_ACK, 19, 500);
    send_item(ACT_ACK, 19, SEQ_LIMIT);
    send_item(ACT_QUIET, 0, 0);
    send_item(ACT_QUIET, 0, SEQ_LIMIT);
    idle_free = 1'b1;
    send_item(ACT_START, 0, 0);
    send_item(ACT_START, 0, 0);
    idle_free = 1'b0;
    repeat (6) send_item(ACT_ACK, 40, 0);
    send_item(ACT_ACK, 0, 0);
    drain_results(SETTLE_CYCLES);
  endtask

  task automatic run_transfers(input int unsigned target);
    int unsigned rounds;
    int unsigned k;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    while (items_sent < target) begin
      idle_free = ($urandom_range(0, 4) == 0);
      send_item(ACT_HANDSHAKE, $urandom_range(0, SEQ_LIMIT), $urandom_range(0, 30000));
      rounds = 0;
      while (items_sent < target && rounds < 12 &&
             !(last_seg_valid && ack_expect - 32'd1 == last_seg_sent)) begin
        rounds++;
        if ($urandom_range(0, 9) == 0) drain_results(1);
        idle_free = ($urandom_range(0, 4) == 0);
        send_item(ACT_START, $urandom_range(0, SEQ_LIMIT), $urandom_range(0, SEQ_LIMIT));
        for (k = $urandom_range(1, 5); k > 0; k--) begin
          pick = $urandom_range(0, 7);
          if (pick < 2) begin
            for (n = $urandom_range(5, 7); n > 0; n--) begin
              send_item(ACT_ACK, ack_expect - 1, calm_elapsed());
            end
          end else if (pick == 2) begin
            send_item(ACT_ACK, $urandom_range(0, ack_expect - 1), calm_elapsed());
          end else if (pick == 3) begin
            send_item(ACT_QUIET, $urandom_range(0, SEQ_LIMIT), calm_elapsed());
          end else begin
            lo = ack_expect - 1;
            hi = (round_stop_seg > ack_expect) ? round_stop_seg - 1 : lo;
            send_item(ACT_ACK, $urandom_range(lo, hi), calm_elapsed());
          end
        end
        lo = rtt_est;
        hi = lo + lo / 4;
        if (hi > SEQ_LIMIT) hi = SEQ_LIMIT;
        if ($urandom_range(0, 4) == 0) begin
          send_item(ACT_QUIET, 0, $urandom_range(lo, hi));
        end else begin
          send_item(ACT_ACK, (round_stop_seg > ack_expect) ? round_stop_seg - 1 : ack_expect - 1,
                    $urandom_range(lo, hi));
        end
      end
    end
  endtask

  task automatic test_random_transfers();
    int unsigned phase;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config($urandom_range(20, 200), $urandom_range(6, 24), $urandom_range(10, 64));
        1: set_config(999999, 64, 64);
        2: set_config($urandom_range(20, 200), 1, 10);
        3: set_config($urandom_range(20, 200), 127, 0);
        default: set_config(SEQ_LIMIT, 0, 127);
      endcase
      run_transfers(items_sent + 40);
      drain_results(SETTLE_CYCLES);
    end
  endtask

  task automatic test_garbage_actions();
    idle_free = 1'b0;
    set_config(0, $urandom_range(0, 127), $urandom_range(0, 127));
    repeat (15) begin
      send_item(action_t'($urandom_range(0, 3)), $urandom_range(0, SEQ_LIMIT),
                $urandom_range(0, SEQ_LIMIT));
    end
    drain_results(SETTLE_CYCLES);
    set_config($urandom_range(1, 60), $urandom_range(0, 127), $urandom_range(0, 127));
    repeat (25) begin
      send_item(action_t'($urandom_range(0, 3)), $urandom_range(0, SEQ_LIMIT),
                $urandom_range(0, SEQ_LIMIT));
    end
    drain_results(SETTLE_CYCLES);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
    end else if (result_valid && !result_stall) begin
      beats_checked++;
      if (predicted_beats.size() == 0) begin
        error_count++;
        $error("result beat with nothing predicted: segment_number %0d", segment_number);
      end else begin
        want = predicted_beats.pop_front();
        if (kind !== want.kind) begin
          error_count++;
          $error("kind: expected %0d, got %0d", want.kind, kind);
        end
        if (segment_number !== want.seg) begin
          error_count++;
          $error("segment_number: expected %0d, got %0d", want.seg, segment_number);
        end
        if (last_of_run !== want.last) begin
          error_count++;
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
        end
        if (round_over !== want.over) begin
          error_count++;
          $error("round_over: expected %0d, got %0d", want.over, round_over);
        end
        if (transfer_done !== want.done) begin
          error_count++;
          $error("transfer_done: expected %0d, got %0d", want.done, transfer_done);
        end
        if (window_now !== want.window) begin
          error_count++;
          $error("window_now: expected %0d, got %0d", want.window, window_now);
        end
        if (rtt_now !== want.rtt) begin
          error_count++;
          $error("rtt_now: expected %0d, got %0d", want.rtt, rtt_now);
        end
        if (quiet_wait_us !== want.quiet) begin
          error_count++;
          $error("quiet_wait_us: expected %0d, got %0d", want.quiet, quiet_wait_us);
        end
      end
      draw = idle_free ? 0 : $urandom_range(0, 6);
      hold_left <= draw;
      result_stall <= (draw != 0);
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_power_on_state();
    test_window_rounds();
    test_random_transfers();
    test_garbage_actions();
    drain_results(SETTLE_CYCLES);
    $display("Drove %0d items through handshakes, rounds, acks and quiet expiries; %0d beats checked.",
             items_sent, beats_checked);
    $display("The run saw %0d retransmissions and %0d round ends over varied window settings.",
             resend_count, round_end_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wsc_pkg.sv
rtl/wsc_rem.sv
rtl/wsc_dp.sv
rtl/wsc_ctrl.sv
rtl/window_sender_congestion_control.sv
sim/window_sender_congestion_control_tb.sv
